[src/ddo_pkg.sv]
// Shared types, constants and helper functions of the differential-drive odometry block.
package ddo_pkg;

  localparam int MD_W        = 64;   // operand width of the multiply/divide unit
  localparam int PROD_W      = 2 * MD_W;
  localparam int COR_W       = 34;   // CORDIC x/y/z register width
  localparam int ANG_W       = 32;   // internal angle, 2^32 = one turn
  localparam int TRAVEL_W    = 48;   // wheel travel, 2^-24 m
  localparam int SD_W        = TRAVEL_W + 1;
  localparam int STEP_W      = 42;   // clamped position step
  localparam int ATAN_IDX_W  = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_EXACT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd6;

  localparam logic [1:0] FAULT_OK            = 2'd0;
  localparam logic [1:0] FAULT_ZERO_INTERVAL = 2'd1;
  localparam logic [1:0] FAULT_SATURATED     = 2'd2;

  localparam logic [MD_W-1:0]         INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic signed [COR_W-1:0] CORDIC_START   = 34'sd652032875;
  localparam logic [23:0]             WHEEL_BASE_RST = 24'd65536;

  typedef enum logic {MD_MUL, MD_DIV} md_op_t;

  typedef struct packed {
    logic                    start;
    md_op_t                  op;
    logic signed [MD_W-1:0]  a;
    logic signed [MD_W-1:0]  b;
  } md_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] value;
  } md_res_t;

  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [COR_W-1:0] cos_v;
    logic signed [COR_W-1:0] sin_v;
  } cor_res_t;

  typedef struct packed {
    logic               restart;
    logic               zero_fault;
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
  } cmd_t;

  typedef struct packed {
    logic               mode_exact;
    logic [31:0]        left_tick_length;
    logic [31:0]        right_tick_length;
    logic [23:0]        wheel_base;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [15:0]        start_heading;
  } cfg_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [ANG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // limit a position step to +-2^40
  function automatic logic signed [STEP_W-1:0] clamp_step(input logic signed [PROD_W-1:0] v);
    logic signed [STEP_W-1:0] r;
    if (v > 128'sh100_0000_0000) begin
      r = 42'sh100_0000_0000;
    end else if (v < -128'sh100_0000_0000) begin
      r = -42'sh100_0000_0000;
    end else begin
      r = v[STEP_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/ddo_if.sv]
// Valid/ready channel interfaces for odometry requests and pose results.
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [15:0] left_ticks;
  logic signed [15:0] right_ticks;
  logic [15:0]        interval;

  modport source (output valid, restart, left_ticks, right_ticks, interval, input ready);
  modport sink   (input valid, restart, left_ticks, right_ticks, interval, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        pose_heading;
  logic [1:0]         fault;

  modport source (output valid, pose_x, pose_y, pose_heading, fault, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, fault, output ready);
endinterface

[src/ddo_front.sv]
// Request intake: clamp tick counts and flag zero intervals before queueing.
module ddo_front import ddo_pkg::*; #(
  parameter int TICK_BITS = 16
) (
  ddo_in_if.sink     in_ch,
  input  logic       mode_exact,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic signed [32:0] TICK_MAX = (33'sd1 <<< (TICK_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] TICK_MIN = -(33'sd1 <<< (TICK_BITS - 1));

  function automatic logic signed [15:0] clamp_ticks(input logic signed [15:0] t);
    logic signed [32:0] ext;
    logic signed [15:0] r;
    ext = {{17{t[15]}}, t};
    if (ext > TICK_MAX) begin
      r = TICK_MAX[15:0];
    end else if (ext < TICK_MIN) begin
      r = TICK_MIN[15:0];
    end else begin
      r = t;
    end
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    cmd.restart     = in_ch.restart;
    cmd.zero_fault  = mode_exact && (in_ch.interval == 16'd0);
    cmd.left_ticks  = clamp_ticks(in_ch.left_ticks);
    cmd.right_ticks = clamp_ticks(in_ch.right_ticks);
  end

endmodule

[src/ddo_queue.sv]
// Two-entry command queue between intake and the pose engine.
module ddo_queue import ddo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;

  assign full    = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end else begin
        count_r <= count_r;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("queue read while empty");

endmodule

[src/ddo_muldiv.sv]
// Shared signed multiplier (8-bit digits) and restoring divider (1 bit per cycle).
module ddo_muldiv import ddo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_res_t res
);

  localparam int DIGIT_W   = 8;
  localparam int MUL_STEPS = MD_W / DIGIT_W;
  localparam int CNT_W     = $clog2(MD_W + 1);

  logic                       busy_r;
  logic                       done_r;
  md_op_t                     op_r;
  logic                       neg_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [MD_W-1:0]            ma_r;
  logic [MD_W-1:0]            mb_r;
  logic [PROD_W-1:0]          acc_r;
  logic [MD_W:0]              rem_r;

  logic [MD_W-1:0]            abs_a;
  logic [MD_W-1:0]            abs_b;
  logic [MD_W+DIGIT_W-1:0]    part;
  logic [PROD_W-1:0]          acc_nxt;
  logic [MD_W:0]              shifted;
  logic [MD_W:0]              trial;
  logic [MD_W-1:0]            quot;

  always_comb begin
    abs_a   = req.a[MD_W-1] ? (~req.a + 1'b1) : req.a;
    abs_b   = req.b[MD_W-1] ? (~req.b + 1'b1) : req.b;
    part    = ma_r * mb_r[MD_W-1 -: DIGIT_W];
    acc_nxt = {acc_r[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
              + {{(PROD_W-MD_W-DIGIT_W){1'b0}}, part};
    shifted = {rem_r[MD_W-1:0], mb_r[MD_W-1]};
    trial   = shifted - {1'b0, ma_r};
    quot    = neg_r ? (~mb_r + 1'b1) : mb_r;
  end

  assign res.done  = done_r;
  assign res.value = (op_r == MD_MUL) ? (neg_r ? (~acc_r + 1'b1) : acc_r)
                                      : {{MD_W{quot[MD_W-1]}}, quot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        op_r   <= req.op;
        neg_r  <= req.a[MD_W-1] ^ req.b[MD_W-1];
        ma_r   <= (req.op == MD_MUL) ? abs_a : abs_b;
        mb_r   <= (req.op == MD_MUL) ? abs_b : abs_a;
        acc_r  <= '0;
        rem_r  <= '0;
        cnt_r  <= (req.op == MD_MUL) ? CNT_W'(MUL_STEPS) : CNT_W'(MD_W);
      end else if (busy_r) begin
        if (op_r == MD_MUL) begin
          acc_r <= acc_nxt;
          mb_r  <= {mb_r[MD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end else if (!trial[MD_W]) begin
          rem_r <= trial;
          mb_r  <= {mb_r[MD_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          mb_r  <= {mb_r[MD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_r)
    else $error("multiply/divide started while busy");

endmodule

[src/ddo_cordic.sv]
// Iterative rotation-mode CORDIC: cosine and sine of a 32-bit binary angle.
module ddo_cordic import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cor_req_t req,
  output cor_res_t res
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  logic                    busy_r;
  logic                    done_r;
  logic                    flip_r;
  logic [IW-1:0]           i_r;
  logic signed [COR_W-1:0] x_r, y_r, z_r;

  logic                    flip;
  logic [ANG_W-1:0]        ang_sum;
  logic [ANG_W-1:0]        ang_fold;
  logic signed [COR_W-1:0] xs, ys, at;
  logic signed [COR_W-1:0] x_nxt, y_nxt, z_nxt;

  always_comb begin
    ang_sum  = req.angle + 32'h4000_0000;
    flip     = ang_sum[ANG_W-1];
    ang_fold = flip ? (req.angle - 32'h8000_0000) : req.angle;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = {{(COR_W-ANG_W){1'b0}}, atan_turn(ATAN_IDX_W'(i_r))};
    if (!z_r[COR_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  assign res.done  = done_r;
  assign res.cos_v = flip_r ? -x_r : x_r;
  assign res.sin_v = flip_r ? -y_r : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        i_r    <= '0;
        flip_r <= flip;
        x_r    <= CORDIC_START;
        y_r    <= '0;
        z_r    <= {{(COR_W-ANG_W){ang_fold[ANG_W-1]}}, ang_fold};
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 1'b1;
        if (i_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_r)
    else $error("CORDIC started while busy");

endmodule

[src/ddo_back.sv]
// Pose engine: sequences the arithmetic units, holds the pose and the result register.
module ddo_back import ddo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  cmd_t     q_cmd,
  output logic     q_pop,
  output md_req_t  md_req,
  input  md_res_t  md_res,
  output cor_req_t cor_req,
  input  cor_res_t cor_res,
  ddo_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_L, S_MUL_R, S_DIV_A, S_MUL_F, S_COR0, S_STR_DX, S_STR_DY,
    S_COR1, S_MUL_NX, S_DIV_G, S_MUL_DX, S_MUL_NY, S_DIV_H, S_MUL_DY, S_UPD, S_OUT
  } state_t;

  state_t                     state_r;
  md_req_t                    md_req_r;
  cor_req_t                   cor_req_r;
  logic signed [31:0]         px_r, py_r;
  logic [15:0]                hd_r;
  logic signed [15:0]         rt_r;
  logic signed [TRAVEL_W-1:0] l_r;
  logic signed [SD_W-1:0]     s_r, d_r;
  logic [ANG_W-1:0]           th1_r;
  logic signed [COR_W-1:0]    c0_r, s0_r, c1_r;
  logic signed [STEP_W-1:0]   dx_r, dy_r;
  logic [1:0]                 fault_r;
  logic                       ov_r;
  logic signed [31:0]         ox_r, oy_r;
  logic [15:0]                oh_r;
  logic [1:0]                 of_r;

  logic signed [PROD_W-1:0]   prod;
  logic [MD_W-1:0]            base64, s64, d64;
  logic [TRAVEL_W-1:0]        r48;
  logic [SD_W-1:0]            sum_s, diff_d;
  logic [TRAVEL_W-1:0]        fsum;
  logic [ANG_W-1:0]           th1;
  logic [ANG_W-1:0]           th_round;
  logic [COR_W:0]             dsin, dcos;
  logic signed [STEP_W-1:0]   step31, step39;
  logic signed [42:0]         sx, sy;
  logic signed [31:0]         nx, ny;
  logic                       sat;

  always_comb begin
    prod     = md_res.value;
    base64   = (cfg.wheel_base == '0) ? 64'd1 : {40'b0, cfg.wheel_base};
    s64      = {{(MD_W-SD_W){s_r[SD_W-1]}}, s_r};
    d64      = {{(MD_W-SD_W){d_r[SD_W-1]}}, d_r};
    r48      = prod[TRAVEL_W-1:0];
    sum_s    = {l_r[TRAVEL_W-1], l_r} + {r48[TRAVEL_W-1], r48};
    diff_d   = {r48[TRAVEL_W-1], r48} - {l_r[TRAVEL_W-1], l_r};
    fsum     = prod[TRAVEL_W-1:0] + 48'h8000;
    th1      = {hd_r, 16'b0} + fsum[TRAVEL_W-1:16];
    th_round = th1_r + 32'h8000;
    dsin     = {cor_res.sin_v[COR_W-1], cor_res.sin_v} - {s0_r[COR_W-1], s0_r};
    dcos     = {c1_r[COR_W-1], c1_r} - {c0_r[COR_W-1], c0_r};
    step31   = clamp_step(prod >>> 31);
    step39   = clamp_step(prod >>> 39);
    sx       = {{11{px_r[31]}}, px_r} + {dx_r[STEP_W-1], dx_r};
    sy       = {{11{py_r[31]}}, py_r} + {dy_r[STEP_W-1], dy_r};
    sat      = 1'b0;
    if (sx > 43'sd2147483647) begin
      nx  = 32'sh7FFF_FFFF;
      sat = 1'b1;
    end else if (sx < -43'sd2147483648) begin
      nx  = 32'sh8000_0000;
      sat = 1'b1;
    end else begin
      nx  = sx[31:0];
    end
    if (sy > 43'sd2147483647) begin
      ny  = 32'sh7FFF_FFFF;
      sat = 1'b1;
    end else if (sy < -43'sd2147483648) begin
      ny  = 32'sh8000_0000;
      sat = 1'b1;
    end else begin
      ny  = sy[31:0];
    end
  end

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign md_req  = md_req_r;
  assign cor_req = cor_req_r;

  assign out_ch.valid        = ov_r;
  assign out_ch.pose_x       = ox_r;
  assign out_ch.pose_y       = oy_r;
  assign out_ch.pose_heading = oh_r;
  assign out_ch.fault        = of_r;

  // Start strobes are set when a unit is launched and dropped on the first
  // wait cycle of the state that follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      md_req_r.start  <= 1'b0;
      cor_req_r.start <= 1'b0;
      ov_r            <= 1'b0;
      px_r            <= '0;
      py_r            <= '0;
      hd_r            <= '0;
    end else begin
      if (ov_r && out_ch.ready && state_r != S_OUT) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.restart) begin
              px_r <= cfg.start_x;
              py_r <= cfg.start_y;
              hd_r <= cfg.start_heading;
            end
            rt_r <= q_cmd.right_ticks;
            if (q_cmd.zero_fault) begin
              fault_r <= FAULT_ZERO_INTERVAL;
              state_r <= S_OUT;
            end else begin
              md_req_r <= '{start: 1'b1, op: MD_MUL,
                            a: {{48{q_cmd.left_ticks[15]}}, q_cmd.left_ticks},
                            b: {32'b0, cfg.left_tick_length}};
              state_r  <= S_MUL_L;
            end
          end
        end
        S_MUL_L: begin
          if (md_res.done) begin
            l_r      <= prod[TRAVEL_W-1:0];
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: {{48{rt_r[15]}}, rt_r},
                          b: {32'b0, cfg.right_tick_length}};
            state_r  <= S_MUL_R;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_MUL_R: begin
          if (md_res.done) begin
            s_r      <= sum_s;
            d_r      <= diff_d;
            // heading delta numerator is D * 256
            md_req_r <= '{start: 1'b1, op: MD_DIV,
                          a: {{(MD_W-SD_W-8){diff_d[SD_W-1]}}, diff_d, 8'b0}, b: base64};
            state_r  <= S_DIV_A;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_DIV_A: begin
          if (md_res.done) begin
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: prod[MD_W-1:0], b: INV_TWO_PI_Q32};
            state_r  <= S_MUL_F;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_MUL_F: begin
          if (md_res.done) begin
            th1_r     <= th1;
            cor_req_r <= '{start: 1'b1, angle: {hd_r, 16'b0}};
            state_r   <= S_COR0;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_COR0: begin
          if (cor_res.done) begin
            c0_r <= cor_res.cos_v;
            s0_r <= cor_res.sin_v;
            if (!cfg.mode_exact || d_r == '0) begin
              md_req_r <= '{start: 1'b1, op: MD_MUL, a: s64,
                            b: {{(MD_W-COR_W){cor_res.cos_v[COR_W-1]}}, cor_res.cos_v}};
              state_r  <= S_STR_DX;
            end else begin
              cor_req_r <= '{start: 1'b1, angle: th1_r};
              state_r   <= S_COR1;
            end
          end else begin
            cor_req_r.start <= 1'b0;
          end
        end
        S_STR_DX: begin
          if (md_res.done) begin
            dx_r     <= step39;
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: s64,
                          b: {{(MD_W-COR_W){s0_r[COR_W-1]}}, s0_r}};
            state_r  <= S_STR_DY;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_STR_DY: begin
          if (md_res.done) begin
            dy_r    <= step39;
            state_r <= S_UPD;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_COR1: begin
          if (cor_res.done) begin
            c1_r     <= cor_res.cos_v;
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: base64,
                          b: {{(MD_W-COR_W-1){dsin[COR_W]}}, dsin}};
            state_r  <= S_MUL_NX;
          end else begin
            cor_req_r.start <= 1'b0;
          end
        end
        S_MUL_NX: begin
          if (md_res.done) begin
            md_req_r <= '{start: 1'b1, op: MD_DIV, a: prod[MD_W-1:0], b: d64};
            state_r  <= S_DIV_G;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_DIV_G: begin
          if (md_res.done) begin
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: s64, b: prod[MD_W-1:0]};
            state_r  <= S_MUL_DX;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_MUL_DX: begin
          if (md_res.done) begin
            dx_r     <= step31;
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: base64,
                          b: {{(MD_W-COR_W-1){dcos[COR_W]}}, dcos}};
            state_r  <= S_MUL_NY;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_MUL_NY: begin
          if (md_res.done) begin
            md_req_r <= '{start: 1'b1, op: MD_DIV, a: prod[MD_W-1:0], b: d64};
            state_r  <= S_DIV_H;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_DIV_H: begin
          if (md_res.done) begin
            md_req_r <= '{start: 1'b1, op: MD_MUL, a: s64, b: prod[MD_W-1:0]};
            state_r  <= S_MUL_DY;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_MUL_DY: begin
          if (md_res.done) begin
            dy_r    <= -step31;
            state_r <= S_UPD;
          end else begin
            md_req_r.start <= 1'b0;
          end
        end
        S_UPD: begin
          px_r    <= nx;
          py_r    <= ny;
          hd_r    <= th_round[ANG_W-1:16];
          fault_r <= sat ? FAULT_SATURATED : FAULT_OK;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r || out_ch.ready) begin
            ov_r    <= 1'b1;
            ox_r    <= px_r;
            oy_r    <= py_r;
            oh_r    <= hd_r;
            of_r    <= fault_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!ov_r || out_ch.ready)) |=> (ov_r && state_r == S_IDLE))
    else $error("finished pose not moved to the result register");

endmodule

[src/diff_drive_odometry_core.sv]
// Top level of the differential-drive wheel odometry block.
//
// Usage:
//   in_ch  : valid/ready request channel with restart, left/right tick counts and
//            the interval. A request is taken when valid and ready are both high.
//   out_ch : valid/ready result channel, one pose (x, y, heading, fault) per request.
//   cfg_*  : write-only register port; cfg_we high writes cfg_wdata to register
//            cfg_index at the clock edge. Write only while no request is in flight.
// Processing: one request is processed at a time by a sequencer sharing one
//   multiply/divide unit and one CORDIC; a zero-interval request in exact mode
//   goes straight to the result register. The divides are the dominant cost.
// A two-entry queue sits in front of the sequencer, so up to two requests are taken
//   while one is being computed; a result register holds the finished pose.
// Reset (rst_n low, synchronous) loads the register defaults and a zero pose.
// When the receiver stalls, the result is held and the sequencer waits after its
//   next pose; the queue then fills and in_ch.ready drops.
module diff_drive_odometry_core import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int TICK_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ddo_in_if.sink                in_ch,
  ddo_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_full;
  logic     push;
  cmd_t     push_cmd;
  logic     q_valid;
  cmd_t     q_cmd;
  logic     q_pop;
  md_req_t  md_req;
  md_res_t  md_res;
  cor_req_t cor_req;
  cor_res_t cor_res;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_exact        <= 1'b1;
      cfg_r.left_tick_length  <= '0;
      cfg_r.right_tick_length <= '0;
      cfg_r.wheel_base        <= WHEEL_BASE_RST;
      cfg_r.start_x           <= '0;
      cfg_r.start_y           <= '0;
      cfg_r.start_heading     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_EXACT:    cfg_r.mode_exact        <= cfg_wdata[0];
        CFG_LEFT_LEN:      cfg_r.left_tick_length  <= cfg_wdata;
        CFG_RIGHT_LEN:     cfg_r.right_tick_length <= cfg_wdata;
        CFG_WHEEL_BASE:    cfg_r.wheel_base        <= cfg_wdata[23:0];
        CFG_START_X:       cfg_r.start_x           <= cfg_wdata;
        CFG_START_Y:       cfg_r.start_y           <= cfg_wdata;
        CFG_START_HEADING: cfg_r.start_heading     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Intake: clamp ticks, tag zero intervals.
  ddo_front #(.TICK_BITS(TICK_BITS)) u_front (
    .in_ch      (in_ch),
    .mode_exact (cfg_r.mode_exact),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Decouple intake from the sequencer.
  ddo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  ddo_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .res   (md_res)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .res   (cor_res)
  );

  // Sequencer, pose state and result register.
  ddo_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .md_req  (md_req),
    .md_res  (md_res),
    .cor_req (cor_req),
    .cor_res (cor_res),
    .out_ch  (out_ch)
  );

endmodule
